@@ design/ria_pkg.sv @@
package ria_pkg;

  localparam int unsigned ID_W            = 10;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned ID_SPACE        = 1 << ID_W;
  localparam int unsigned ID_CAPACITY_DEF = 1024;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] target_id;
  } ria_in_t;

  typedef struct packed {
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
  } ria_out_t;

  // read request to the store, addresses are part-selected inside
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] stack_addr;
    logic [ID_W-1:0] flag_addr;
  } ria_rd_t;

  // write request to the store
  typedef struct packed {
    logic            stack_we;
    logic [ID_W-1:0] stack_addr;
    logic [ID_W-1:0] stack_data;
    logic            flag_we;
    logic [ID_W-1:0] flag_addr;
    logic            flag_data;
  } ria_wr_t;

endpackage

@@ design/recycling_id_allocator_core.sv @@
// recycling id allocator: hands out small ids and takes them back
// input channel in_valid_i/in_ready_o carries one request word: opcode selects
//   allocate (target_id ignored) or free of target_id
// output channel out_valid_o/out_ready_i carries one result word per request:
//   granted_id and status (ok, bad free, exhausted)
// allocate pops the most recently freed id, else issues the next fresh id
//   from the high-water counter, else reports exhausted
// a request accepted in the idle state has the stack and flag memories read;
//   the decide state then writes back and loads the result into out_word_o
//   once the output register is free, and no new request is accepted until
//   the previous one has been decided
// in_ready_o is high whenever no request is in flight, also while a result
//   waits in the output register; a stalled receiver holds the result and a
//   second request then waits after its memory read until the output frees
// reset clears the state, output register, stack depth and high-water counter,
//   not the memories; no clearing pass runs, since a flag entry is written when
//   its id is first issued and no flag above the high-water mark is ever consulted
module recycling_id_allocator_core import ria_pkg::*; #(
  parameter int unsigned ID_CAPACITY = ID_CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ria_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ria_out_t out_word_o
);

  // only ids below 2^ID_W can be freed, so the stack never holds more
  localparam int unsigned STACK_DEPTH = (ID_CAPACITY < ID_SPACE) ? ID_CAPACITY : ID_SPACE;
  localparam int unsigned HW_W        = $clog2(ID_CAPACITY + 1);
  localparam int unsigned SD_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMP_W       = (HW_W > ID_W) ? HW_W : ID_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e           state_q, state_d;
  logic [HW_W-1:0]  hw_q, hw_d;
  logic [SD_W-1:0]  depth_q, depth_d;
  logic             out_valid_q, out_valid_d;
  ria_out_t         out_word_q, out_word_d;
  ria_in_t          in_q;

  logic             in_fire;
  logic             out_free;
  logic             finish;
  logic [SD_W-1:0]  depth_dec;
  ria_rd_t          rd;
  ria_wr_t          wr;
  ria_wr_t          exec_wr;
  ria_out_t         exec_out;
  logic [HW_W-1:0]  exec_hw;
  logic [SD_W-1:0]  exec_depth;
  logic [ID_W-1:0]  stack_rdata;
  logic             flag_rdata;
  logic             stack_empty;
  logic             stack_full;
  logic             hw_full;
  logic             id_known;

  // handshake
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign finish     = (state_q == S_EXEC) && out_free;

  // read the stack top and the target's flag as the request comes in
  assign depth_dec     = depth_q - SD_W'(1);
  assign rd.en         = in_fire;
  assign rd.stack_addr = ID_W'(depth_dec);
  assign rd.flag_addr  = in_word_i.target_id;

  ria_store #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rd_i         (rd),
    .wr_i         (wr),
    .stack_rdata_o(stack_rdata),
    .flag_rdata_o (flag_rdata)
  );

  // decide and build the write-back from the read data
  always_comb begin
    stack_empty = (depth_q == '0);
    stack_full  = (depth_q == SD_W'(STACK_DEPTH));
    hw_full     = (hw_q == HW_W'(ID_CAPACITY));
    // any id below the high-water mark has had its flag written
    id_known    = (CMP_W'(in_q.target_id) < CMP_W'(hw_q)) &&
                  (CMP_W'(in_q.target_id) < CMP_W'(ID_CAPACITY));

    exec_out.granted_id = '0;
    exec_out.status     = STATUS_OK;
    exec_wr             = '0;
    exec_hw             = hw_q;
    exec_depth          = depth_q;

    if (in_q.opcode == OP_ALLOC) begin
      if (!stack_empty) begin
        // pop the most recently freed id
        exec_out.granted_id = stack_rdata;
        exec_wr.flag_we     = 1'b1;
        exec_wr.flag_addr   = stack_rdata;
        exec_wr.flag_data   = 1'b0;
        exec_depth          = depth_dec;
      end else if (hw_full) begin
        exec_out.status = STATUS_EXHAUSTED;
      end else begin
        // fresh id, its flag entry gets its first write here
        exec_out.granted_id = ID_W'(hw_q);
        exec_hw             = hw_q + HW_W'(1);
        exec_wr.flag_we     = (hw_q < HW_W'(STACK_DEPTH));
        exec_wr.flag_addr   = ID_W'(hw_q);
        exec_wr.flag_data   = 1'b0;
      end
    end else begin
      if (!id_known || flag_rdata || stack_full) begin
        exec_out.status = STATUS_BAD_FREE;
      end else begin
        // push onto the free stack and mark free
        exec_wr.stack_we   = 1'b1;
        exec_wr.stack_addr = ID_W'(depth_q);
        exec_wr.stack_data = in_q.target_id;
        exec_wr.flag_we    = 1'b1;
        exec_wr.flag_addr  = in_q.target_id;
        exec_wr.flag_data  = 1'b1;
        exec_depth         = depth_q + SD_W'(1);
      end
    end
  end

  // write back only when the result can be loaded
  assign wr = finish ? exec_wr : '0;

  always_comb begin
    state_d     = state_q;
    hw_d        = hw_q;
    depth_d     = depth_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_d     = S_IDLE;
          hw_d        = exec_hw;
          depth_d     = exec_depth;
          out_valid_d = 1'b1;
          out_word_d  = exec_out;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  // request word held for the decide cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_word_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a stalled result keeps the pending request parked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && !out_ready_i) |=> (state_q == S_EXEC))
    else $error("pending request left decide state while output stalled");

  // every id on the stack was issued before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMP_W'(depth_q) <= CMP_W'(hw_q)) && (hw_q <= HW_W'(ID_CAPACITY)))
    else $error("stack depth or high-water mark out of range");

  // exhausted only with an empty stack and every id issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && exec_out.status == STATUS_EXHAUSTED) |-> (stack_empty && hw_full))
    else $error("exhausted reported while ids remain");

  // counters move only when a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finish |=> ($stable(hw_q) && $stable(depth_q)))
    else $error("counters changed without a result");

  // memories are never written while a request is being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (!wr.stack_we && !wr.flag_we))
    else $error("write collides with request read");

endmodule

@@ design/ria_store.sv @@
module ria_store import ria_pkg::*; #(
  parameter int unsigned STACK_DEPTH = ID_SPACE
) (
  input  logic            clk_i,
  input  ria_rd_t         rd_i,
  input  ria_wr_t         wr_i,
  output logic [ID_W-1:0] stack_rdata_o,
  output logic            flag_rdata_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // free stack and per-id free flags, registered read
  logic [ID_W-1:0] stack_mem [STACK_DEPTH];
  logic            flag_mem  [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.stack_we) begin
      stack_mem[wr_i.stack_addr[AW-1:0]] <= wr_i.stack_data;
    end
    if (wr_i.flag_we) begin
      flag_mem[wr_i.flag_addr[AW-1:0]] <= wr_i.flag_data;
    end
    if (rd_i.en) begin
      stack_rdata_o <= stack_mem[rd_i.stack_addr[AW-1:0]];
      flag_rdata_o  <= flag_mem[rd_i.flag_addr[AW-1:0]];
    end
  end

endmodule
